// ----- hw/rtl/fractional_max_pool_2d_defines.svh -----
// Assertion macros used by the checker file
`ifndef FRACTIONAL_MAX_POOL_2D_DEFINES_SVH
`define FRACTIONAL_MAX_POOL_2D_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmp check failed");

// next-cycle implication
`define FMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmp check failed");

`endif

// ----- hw/rtl/fmp_pkg.sv -----
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared constants and types of the fractional max pooling block.
// ----------------------------------------------------------------------------
package fmp_pkg;

    // fixed field widths
    localparam int COORD_W    = 9;
    localparam int OUTN_W     = 8;
    localparam int POOL_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int ALPHA_W    = 25;
    localparam int OFFS_W     = 9;
    localparam int START_W    = 17;
    localparam int IDX_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int POOL_MAX_DEF   = 8;
    localparam int PIXEL_BITS_DEF = 16;

    // register reset values
    localparam logic [8:0] RST_IN_WIDTH   = 9'd32;
    localparam logic [8:0] RST_IN_HEIGHT  = 9'd32;
    localparam logic [7:0] RST_OUT_WIDTH  = 8'd16;
    localparam logic [7:0] RST_OUT_HEIGHT = 8'd16;
    localparam logic [3:0] RST_POOL       = 4'd2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH    = 3'd0,
        CFG_IN_HEIGHT   = 3'd1,
        CFG_OUT_WIDTH   = 3'd2,
        CFG_OUT_HEIGHT  = 3'd3,
        CFG_POOL_WIDTH  = 3'd4,
        CFG_POOL_HEIGHT = 3'd5,
        CFG_INDEX_BASE  = 3'd6
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_W,
        S_DIV_H,
        S_OFFS,
        S_MUL,
        S_CMP,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } state_t;

endpackage

// ----- hw/rtl/fmp_pix_if.sv -----
// ----------------------------------------------------------------------------
// fmp_pix_if
// Pixel input channel: one pixel and the two random samples per beat.
// ----------------------------------------------------------------------------
interface fmp_pix_if #(
    parameter int PIXEL_BITS = fmp_pkg::PIXEL_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [PIXEL_BITS-1:0]  pixel;
    logic [fmp_pkg::SAMPLE_W-1:0]  sample_w;
    logic [fmp_pkg::SAMPLE_W-1:0]  sample_h;

    modport source (output valid, pixel, sample_w, sample_h, input ready);
    modport sink   (input valid, pixel, sample_w, sample_h, output ready);
endinterface

// ----- hw/rtl/fmp_res_if.sv -----
// ----------------------------------------------------------------------------
// fmp_res_if
// Result channel: one pooled window per beat.
// ----------------------------------------------------------------------------
interface fmp_res_if #(
    parameter int PIXEL_BITS = fmp_pkg::PIXEL_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [PIXEL_BITS-1:0]  max_value;
    logic [fmp_pkg::IDX_W-1:0]     max_index;
    logic [fmp_pkg::OUTN_W-1:0]    out_row;
    logic [fmp_pkg::OUTN_W-1:0]    out_col;
    logic                          last_of_plane;

    modport source (output valid, max_value, max_index, out_row, out_col, last_of_plane,
                    input ready);
    modport sink   (input valid, max_value, max_index, out_row, out_col, last_of_plane,
                    output ready);
endinterface

// ----- hw/rtl/fmp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// fmp_cfg_if
// Register write channel: index and data per beat.
// ----------------------------------------------------------------------------
interface fmp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fmp_pkg::CFG_IDX_W-1:0]   index;
    logic [fmp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fractional_max_pool_2d.sv -----
// A pixel that closes a window is followed by a scan of that window through the
// single read port of the row memory, one pixel per cycle. A plane's first pixel
// also waits for the two serial divisions of the step sizes (one bit per cycle).
// Reset (rst_n, asynchronous, low) restores register defaults and clears the
// pixel and window counters; the row memory is not cleared.
// ----------------------------------------------------------------------------
// fractional_max_pool_2d
// Fractional max pooling over one plane in raster order, row ring in memory.
// ----------------------------------------------------------------------------
module fractional_max_pool_2d #(
    parameter int MAX_WIDTH  = fmp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fmp_pkg::MAX_HEIGHT_DEF,
    parameter int POOL_MAX   = fmp_pkg::POOL_MAX_DEF,
    parameter int PIXEL_BITS = fmp_pkg::PIXEL_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fmp_pix_if.sink   pix,
    fmp_res_if.source res,
    fmp_cfg_if.sink   cfg
);

    localparam int CW     = fmp_pkg::COORD_W;
    localparam int NW     = fmp_pkg::OUTN_W;
    localparam int PW     = fmp_pkg::POOL_W;
    localparam int AL     = fmp_pkg::ALPHA_W;
    localparam int OW     = fmp_pkg::OFFS_W;
    localparam int SW     = fmp_pkg::START_W;
    localparam int DEPTH  = POOL_MAX * MAX_WIDTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
    localparam int SLX_W  = $clog2(2 * POOL_MAX + 1) + 1;
    localparam int PROD_W = NW + fmp_pkg::SAMPLE_W + AL;

    // configuration registers
    logic [8:0]    cfg_iw_reg, cfg_ih_reg;
    logic [7:0]    cfg_ow_reg, cfg_oh_reg;
    logic [3:0]    cfg_pw_reg, cfg_ph_reg;
    logic          cfg_base_reg;

    // state
    fmp_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   pcol_reg, pcol_next, prow_reg, prow_next;
    logic [SLOT_W-1:0] pslot_reg, pslot_next;
    logic [AL-1:0]   alpha_w_reg, alpha_w_next, alpha_h_reg, alpha_h_next;
    logic [OW-1:0]   offs_w_reg, offs_w_next, offs_h_reg, offs_h_next;
    logic [fmp_pkg::SAMPLE_W-1:0] smp_w_reg, smp_w_next, smp_h_reg, smp_h_next;
    logic [NW-1:0]   nwc_reg, nwc_next, nwr_reg, nwr_next;
    logic [PROD_W-1:0] prod_w_reg, prod_w_next, prod_h_reg, prod_h_next;

    // scan
    logic [CW-1:0]   sx_reg, sx_next, sy_reg, sy_next, x0_reg, x0_next;
    logic [SLOT_W-1:0] sslot_reg, sslot_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic signed [PIXEL_BITS-1:0] best_reg, best_next;
    logic [CW-1:0]   best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic            have_reg, have_next;

    // output register
    logic            ov_reg, ov_next;
    logic signed [PIXEL_BITS-1:0] o_val_reg, o_val_next;
    logic [fmp_pkg::IDX_W-1:0] o_idx_reg, o_idx_next;
    logic [NW-1:0]   o_row_reg, o_row_next, o_col_reg, o_col_next;
    logic            o_last_reg, o_last_next;

    // live sizes
    logic [CW-1:0] iw, ih, span_w, span_h;
    logic [NW-1:0] ow, oh;
    logic [PW-1:0] pw, ph;

    // helpers
    logic          pix_acc, first_px;
    logic          div_start, div_done;
    logic [AL-1:0] div_dvd, div_q;
    logic [NW-1:0] div_dvs;
    logic [AW-1:0] waddr, raddr;
    logic signed [PIXEL_BITS-1:0] rdata;
    logic [SW-1:0] hs, ws;
    logic          last_c, last_r, hit;
    logic [SLX_W-1:0] slot_tmp;
    logic [CW-1:0] adv_col, adv_row;
    logic [SLOT_W-1:0] adv_slot;
    logic          do_adv;
    logic [2*CW-1:0] idx_full;

    // clamp register values to the legal ranges
    always_comb
    begin
        iw = (cfg_iw_reg < 9'd2) ? CW'(2)
           : (32'(cfg_iw_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : cfg_iw_reg;
        ih = (cfg_ih_reg < 9'd2) ? CW'(2)
           : (32'(cfg_ih_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : cfg_ih_reg;
        ow = (cfg_ow_reg == '0) ? NW'(1) : cfg_ow_reg;
        oh = (cfg_oh_reg == '0) ? NW'(1) : cfg_oh_reg;
        pw = (cfg_pw_reg == '0) ? PW'(1)
           : (32'(cfg_pw_reg) > POOL_MAX) ? PW'(POOL_MAX) : cfg_pw_reg;
        ph = (cfg_ph_reg == '0) ? PW'(1)
           : (32'(cfg_ph_reg) > POOL_MAX) ? PW'(POOL_MAX) : cfg_ph_reg;
        span_w = (iw > CW'(pw)) ? iw - CW'(pw) : '0;
        span_h = (ih > CW'(ph)) ? ih - CW'(ph) : '0;
    end

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_iw_reg   <= fmp_pkg::RST_IN_WIDTH;
            cfg_ih_reg   <= fmp_pkg::RST_IN_HEIGHT;
            cfg_ow_reg   <= fmp_pkg::RST_OUT_WIDTH;
            cfg_oh_reg   <= fmp_pkg::RST_OUT_HEIGHT;
            cfg_pw_reg   <= fmp_pkg::RST_POOL;
            cfg_ph_reg   <= fmp_pkg::RST_POOL;
            cfg_base_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (fmp_pkg::cfg_reg_t'(cfg.index))
                fmp_pkg::CFG_IN_WIDTH:    cfg_iw_reg   <= cfg.data;
                fmp_pkg::CFG_IN_HEIGHT:   cfg_ih_reg   <= cfg.data;
                fmp_pkg::CFG_OUT_WIDTH:   cfg_ow_reg   <= cfg.data[7:0];
                fmp_pkg::CFG_OUT_HEIGHT:  cfg_oh_reg   <= cfg.data[7:0];
                fmp_pkg::CFG_POOL_WIDTH:  cfg_pw_reg   <= cfg.data[3:0];
                fmp_pkg::CFG_POOL_HEIGHT: cfg_ph_reg   <= cfg.data[3:0];
                fmp_pkg::CFG_INDEX_BASE:  cfg_base_reg <= cfg.data[0];
                default:                  ;
            endcase
        end
    end

    // handshakes
    assign pix.ready = (state_reg == fmp_pkg::S_IDLE);
    assign pix_acc   = pix.valid && pix.ready;
    assign first_px  = (prow_reg == '0) && (pcol_reg == '0);

    // row memory
    assign waddr = AW'(int'(pslot_reg) * MAX_WIDTH + int'(pcol_reg));
    assign raddr = AW'(int'(sslot_reg) * MAX_WIDTH + int'(sx_reg));

    fmp_row_mem #(
        .DEPTH      (DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (pix_acc),
        .waddr (waddr),
        .wdata (pix.pixel),
        .raddr (raddr),
        .rdata (rdata)
    );

    // step size divider, width axis first then height
    assign div_dvd = (state_reg == fmp_pkg::S_IDLE) ? {span_w, 16'd0} : {span_h, 16'd0};
    assign div_dvs = (state_reg == fmp_pkg::S_IDLE) ? ow - 1'b1 : oh - 1'b1;

    fmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // window starts from the registered products
    always_comb
    begin
        last_c = ({1'b0, nwc_reg} + 1'b1) >= {1'b0, ow};
        last_r = ({1'b0, nwr_reg} + 1'b1) >= {1'b0, oh};
        ws = last_c ? SW'(span_w) : prod_w_reg[PROD_W-1:32] - SW'(offs_w_reg);
        hs = last_r ? SW'(span_h) : prod_h_reg[PROD_W-1:32] - SW'(offs_h_reg);
        hit = (nwr_reg < oh) && (nwc_reg < ow)
            && ((SW+1)'(hs) + (SW+1)'(ph) - 1'b1 == (SW+1)'(prow_reg))
            && ((SW+1)'(ws) + (SW+1)'(pw) - 1'b1 == (SW+1)'(pcol_reg));
        slot_tmp = SLX_W'(pslot_reg) + SLX_W'(POOL_MAX) - SLX_W'(ph) + 1'b1;
        if (slot_tmp >= SLX_W'(POOL_MAX))
        begin
            slot_tmp = slot_tmp - SLX_W'(POOL_MAX);
        end
    end

    // pixel position after this beat
    always_comb
    begin
        if (({1'b0, pcol_reg} + 1'b1) >= {1'b0, iw})
        begin
            adv_col = '0;
            if (({1'b0, prow_reg} + 1'b1) >= {1'b0, ih})
            begin
                adv_row  = '0;
                adv_slot = '0;
            end
            else
            begin
                adv_row  = prow_reg + 1'b1;
                adv_slot = (32'(pslot_reg) + 1 == POOL_MAX) ? '0 : pslot_reg + 1'b1;
            end
        end
        else
        begin
            adv_col  = pcol_reg + 1'b1;
            adv_row  = prow_reg;
            adv_slot = pslot_reg;
        end
    end

    assign idx_full = best_y_reg * iw;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        alpha_w_next = alpha_w_reg;
        alpha_h_next = alpha_h_reg;
        offs_w_next  = offs_w_reg;
        offs_h_next  = offs_h_reg;
        smp_w_next   = smp_w_reg;
        smp_h_next   = smp_h_reg;
        nwc_next     = nwc_reg;
        nwr_next     = nwr_reg;
        prod_w_next  = prod_w_reg;
        prod_h_next  = prod_h_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        x0_next      = x0_reg;
        sslot_next   = sslot_reg;
        pend_next    = 1'b0;
        pend_x_next  = sx_reg;
        pend_y_next  = sy_reg;
        best_next    = best_reg;
        best_x_next  = best_x_reg;
        best_y_next  = best_y_reg;
        have_next    = have_reg;
        ov_next      = ov_reg && !res.ready;
        o_val_next   = o_val_reg;
        o_idx_next   = o_idx_reg;
        o_row_next   = o_row_reg;
        o_col_next   = o_col_reg;
        o_last_next  = o_last_reg;
        div_start    = 1'b0;
        do_adv       = 1'b0;

        // compare the word read in the previous cycle
        if (pend_reg && (!have_reg || rdata > best_reg))
        begin
            best_next   = rdata;
            best_x_next = pend_x_reg;
            best_y_next = pend_y_reg;
            have_next   = 1'b1;
        end

        unique case (state_reg)
            fmp_pkg::S_IDLE:
            begin
                if (pix_acc)
                begin
                    if (first_px)
                    begin
                        smp_w_next = pix.sample_w;
                        smp_h_next = pix.sample_h;
                        div_start  = 1'b1;
                        state_next = fmp_pkg::S_DIV_W;
                    end
                    else
                    begin
                        state_next = fmp_pkg::S_MUL;
                    end
                end
            end
            fmp_pkg::S_DIV_W:
            begin
                if (div_done)
                begin
                    alpha_w_next = (ow <= NW'(1)) ? '0 : div_q;
                    div_start    = 1'b1;
                    state_next   = fmp_pkg::S_DIV_H;
                end
            end
            fmp_pkg::S_DIV_H:
            begin
                if (div_done)
                begin
                    alpha_h_next = (oh <= NW'(1)) ? '0 : div_q;
                    state_next   = fmp_pkg::S_OFFS;
                end
            end
            fmp_pkg::S_OFFS:
            begin
                prod_w_next = PROD_W'(smp_w_reg) * PROD_W'(alpha_w_reg);
                prod_h_next = PROD_W'(smp_h_reg) * PROD_W'(alpha_h_reg);
                offs_w_next = OW'(prod_w_next[PROD_W-1:32]);
                offs_h_next = OW'(prod_h_next[PROD_W-1:32]);
                nwc_next    = '0;
                nwr_next    = '0;
                state_next  = fmp_pkg::S_MUL;
            end
            fmp_pkg::S_MUL:
            begin
                prod_w_next = PROD_W'({nwc_reg, smp_w_reg}) * PROD_W'(alpha_w_reg);
                prod_h_next = PROD_W'({nwr_reg, smp_h_reg}) * PROD_W'(alpha_h_reg);
                state_next  = fmp_pkg::S_CMP;
            end
            fmp_pkg::S_CMP:
            begin
                if (hit)
                begin
                    sy_next    = prow_reg + 1'b1 - CW'(ph);
                    sx_next    = pcol_reg + 1'b1 - CW'(pw);
                    x0_next    = pcol_reg + 1'b1 - CW'(pw);
                    sslot_next = SLOT_W'(slot_tmp);
                    have_next  = 1'b0;
                    state_next = fmp_pkg::S_SCAN;
                end
                else
                begin
                    do_adv     = 1'b1;
                    state_next = fmp_pkg::S_IDLE;
                end
            end
            fmp_pkg::S_SCAN:
            begin
                // raddr is issued this cycle; data arrives next cycle
                pend_next = 1'b1;
                if (sx_reg == pcol_reg)
                begin
                    sx_next    = x0_reg;
                    sy_next    = sy_reg + 1'b1;
                    sslot_next = (32'(sslot_reg) + 1 == POOL_MAX) ? '0 : sslot_reg + 1'b1;
                    if (sy_reg == prow_reg)
                    begin
                        state_next = fmp_pkg::S_DRAIN;
                    end
                end
                else
                begin
                    sx_next = sx_reg + 1'b1;
                end
            end
            fmp_pkg::S_DRAIN:
            begin
                state_next = fmp_pkg::S_FIN;
            end
            fmp_pkg::S_FIN:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next     = 1'b1;
                    o_val_next  = best_reg;
                    o_idx_next  = fmp_pkg::IDX_W'(idx_full + (2*CW)'(best_x_reg)
                                                  + (2*CW)'(cfg_base_reg));
                    o_row_next  = nwr_reg;
                    o_col_next  = nwc_reg;
                    o_last_next = (nwr_reg + 1'b1 == oh) && (nwc_reg + 1'b1 == ow);
                    if (last_c)
                    begin
                        nwc_next = '0;
                        nwr_next = nwr_reg + 1'b1;
                    end
                    else
                    begin
                        nwc_next = nwc_reg + 1'b1;
                    end
                    do_adv     = 1'b1;
                    state_next = fmp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fmp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pcol_next  = do_adv ? adv_col  : pcol_reg;
        prow_next  = do_adv ? adv_row  : prow_reg;
        pslot_next = do_adv ? adv_slot : pslot_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmp_pkg::S_IDLE;
            pcol_reg  <= '0;
            prow_reg  <= '0;
            pslot_reg <= '0;
            alpha_w_reg <= '0;
            alpha_h_reg <= '0;
            offs_w_reg  <= '0;
            offs_h_reg  <= '0;
            smp_w_reg   <= '0;
            smp_h_reg   <= '0;
            nwc_reg     <= '0;
            nwr_reg     <= '0;
            pend_reg    <= 1'b0;
            have_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
            pslot_reg <= pslot_next;
            alpha_w_reg <= alpha_w_next;
            alpha_h_reg <= alpha_h_next;
            offs_w_reg  <= offs_w_next;
            offs_h_reg  <= offs_h_next;
            smp_w_reg   <= smp_w_next;
            smp_h_reg   <= smp_h_next;
            nwc_reg     <= nwc_next;
            nwr_reg     <= nwr_next;
            pend_reg    <= pend_next;
            have_reg    <= have_next;
            ov_reg      <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_w_reg <= prod_w_next;
        prod_h_reg <= prod_h_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        x0_reg     <= x0_next;
        sslot_reg  <= sslot_next;
        pend_x_reg <= pend_x_next;
        pend_y_reg <= pend_y_next;
        best_reg   <= best_next;
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;
        o_val_reg  <= o_val_next;
        o_idx_reg  <= o_idx_next;
        o_row_reg  <= o_row_next;
        o_col_reg  <= o_col_next;
        o_last_reg <= o_last_next;
    end

    // result port
    assign res.valid         = ov_reg;
    assign res.max_value     = o_val_reg;
    assign res.max_index     = o_idx_reg;
    assign res.out_row       = o_row_reg;
    assign res.out_col       = o_col_reg;
    assign res.last_of_plane = o_last_reg;

endmodule

// ----- hw/rtl/fmp_row_mem.sv -----
// ----------------------------------------------------------------------------
// fmp_row_mem
// Ring of recent pixel rows: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmp_row_mem #(
    parameter int DEPTH      = fmp_pkg::POOL_MAX_DEF * fmp_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = fmp_pkg::PIXEL_BITS_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic signed [PIXEL_BITS-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic signed [PIXEL_BITS-1:0] rdata
);

    logic signed [PIXEL_BITS-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/fmp_div.sv -----
// ----------------------------------------------------------------------------
// fmp_div
// Restoring divider, one quotient bit per cycle, for the window step size.
// ----------------------------------------------------------------------------
module fmp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fmp_pkg::ALPHA_W-1:0]  dividend,
    input  logic [fmp_pkg::OUTN_W-1:0]   divisor,
    output logic                         done,
    output logic [fmp_pkg::ALPHA_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(fmp_pkg::ALPHA_W + 1);

    logic [fmp_pkg::ALPHA_W-1:0]  q_reg;
    logic [fmp_pkg::OUTN_W-1:0]   rem_reg;
    logic [fmp_pkg::OUTN_W-1:0]   dvs_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [fmp_pkg::OUTN_W:0]     trial;
    logic                         qbit;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, q_reg[fmp_pkg::ALPHA_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[fmp_pkg::ALPHA_W-2:0], qbit};
                rem_reg <= qbit ? fmp_pkg::OUTN_W'(trial - {1'b0, dvs_reg})
                                : fmp_pkg::OUTN_W'(trial);
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(fmp_pkg::ALPHA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hw/rtl/fmp_checker.sv -----
// ----------------------------------------------------------------------------
// fmp_checker
// Port-level checks of the pooling block, bound to the top level.
// ----------------------------------------------------------------------------
`include "fractional_max_pool_2d_defines.svh"

module fmp_checker #(
    parameter int PIXEL_BITS = fmp_pkg::PIXEL_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [PIXEL_BITS-1:0] out_value,
    input logic [fmp_pkg::IDX_W-1:0]    out_index
);

    // a stalled result beat stays up
    `FMP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

    // a stalled result beat keeps its payload
    `FMP_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_value) && $stable(out_index))

    // one pixel at a time: the input closes after each beat
    `FMP_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready)

    // a result never follows its pixel in the very next cycle
    `FMP_ASSERT_NXT(a_no_fast_result, in_valid && in_ready, !$rose(out_valid))

endmodule

bind fractional_max_pool_2d fmp_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_fmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_value (res.max_value),
    .out_index (res.max_index)
);

// ----- tb/fractional_max_pool_2d_tb.sv -----
// ----------------------------------------------------------------------------
// fractional_max_pool_2d_tb
// Sends whole planes of pixels under many size settings. A local copy of the
// pooling logic works out each window result. Every result beat is checked
// field by field, in order, against that copy. Both channels pause at random.
// ----------------------------------------------------------------------------
module fractional_max_pool_2d_tb;

    localparam int  RING_ROWS   = 8;
    localparam int  RING_COLS   = 256;
    localparam int  PIX_TARGET  = 1450;
    localparam int  SETTLE_CYC  = 120;
    localparam int  CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [15:0] max_value;
        logic [16:0] max_index;
        logic [7:0]  out_row;
        logic [7:0]  out_col;
        logic        last_of_plane;
    } window_t;

    logic clk;
    logic rst_n;

    fmp_pix_if pix_ch ();
    fmp_res_if res_ch ();
    fmp_cfg_if cfg_ch ();

    fractional_max_pool_2d i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // pooling state mirrored from the block
    int unsigned       reg_val [7];
    logic signed [15:0] ring_mem [RING_ROWS*RING_COLS];
    int unsigned       cur_col, cur_row;
    longint unsigned   step_w, step_h, offs_w, offs_h;
    int unsigned       smp_w, smp_h, win_col, win_row;

    window_t           pending_windows [$];
    int                error_count;
    int                cycle_count;
    int                pixels_sent;
    bit                quiet;
    int                res_stall;
    int                res_gap;

    // ------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned span_of(int unsigned n_in, int unsigned pool);
        return (n_in > pool) ? longint'(n_in - pool) : 64'd0;
    endfunction

    function automatic longint unsigned step_of(int unsigned n_in, int unsigned pool,
                                                int unsigned n_out);
        if (n_out <= 1) return 0;
        return (span_of(n_in, pool) << 16) / longint'(n_out - 1);
    endfunction

    function automatic longint unsigned start_of(int unsigned i, int unsigned n_out,
                                                 int unsigned n_in, int unsigned pool,
                                                 longint unsigned step, int unsigned s,
                                                 longint unsigned offs);
        longint unsigned q;
        if (i + 1 >= n_out) return span_of(n_in, pool);
        q = ((longint'(i) << 16) + longint'(s)) * step;
        return (q >> 32) - offs;
    endfunction

    function automatic void store_reg(int unsigned idx, int unsigned val);
        case (idx)
            fmp_pkg::CFG_IN_WIDTH, fmp_pkg::CFG_IN_HEIGHT:
                reg_val[idx] = val & 9'h1FF;
            fmp_pkg::CFG_OUT_WIDTH, fmp_pkg::CFG_OUT_HEIGHT:
                reg_val[idx] = val & 8'hFF;
            fmp_pkg::CFG_POOL_WIDTH, fmp_pkg::CFG_POOL_HEIGHT:
                reg_val[idx] = val & 4'hF;
            fmp_pkg::CFG_INDEX_BASE:
                reg_val[idx] = val & 1'b1;
            default: ;
        endcase
    endfunction

    // work out the window (if any) closed by one accepted pixel
    function automatic void pool_pixel(logic [15:0] px, logic [15:0] sw, logic [15:0] sh);
        int unsigned     iw, ih, ow, oh, pw, ph, r, c, y, x;
        longint unsigned hs, ws, best_idx;
        logic signed [15:0] best, v;
        bit              have;
        window_t         w;
        iw = clamp_u(reg_val[fmp_pkg::CFG_IN_WIDTH], 2, 256);
        ih = clamp_u(reg_val[fmp_pkg::CFG_IN_HEIGHT], 2, 256);
        ow = clamp_u(reg_val[fmp_pkg::CFG_OUT_WIDTH], 1, 255);
        oh = clamp_u(reg_val[fmp_pkg::CFG_OUT_HEIGHT], 1, 255);
        pw = clamp_u(reg_val[fmp_pkg::CFG_POOL_WIDTH], 1, 8);
        ph = clamp_u(reg_val[fmp_pkg::CFG_POOL_HEIGHT], 1, 8);
        r  = cur_row;
        c  = cur_col;
        // plane start latches samples and step sizes
        if (r == 0 && c == 0)
        begin
            smp_w   = sw;
            smp_h   = sh;
            step_w  = step_of(iw, pw, ow);
            step_h  = step_of(ih, ph, oh);
            offs_w  = (longint'(smp_w) * step_w) >> 32;
            offs_h  = (longint'(smp_h) * step_h) >> 32;
            win_col = 0;
            win_row = 0;
        end
        ring_mem[(r % RING_ROWS) * RING_COLS + (c % RING_COLS)] = px;
        if (win_row < oh && win_col < ow)
        begin
            hs = start_of(win_row, oh, ih, ph, step_h, smp_h, offs_h);
            ws = start_of(win_col, ow, iw, pw, step_w, smp_w, offs_w);
            if (hs + ph - 1 == r && ws + pw - 1 == c)
            begin
                have = 0;
                best = '0;
                best_idx = 0;
                for (y = r + 1 - ph; y <= r; y++)
                    for (x = c + 1 - pw; x <= c; x++)
                    begin
                        v = ring_mem[(y % RING_ROWS) * RING_COLS + (x % RING_COLS)];
                        if (!have || v > best)
                        begin
                            best = v;
                            best_idx = longint'(y) * iw + x;
                            have = 1;
                        end
                    end
                w.max_value     = best;
                w.max_index     = 17'(best_idx + reg_val[fmp_pkg::CFG_INDEX_BASE]);
                w.out_row       = 8'(win_row);
                w.out_col       = 8'(win_col);
                w.last_of_plane = (win_row + 1 == oh && win_col + 1 == ow);
                pending_windows.push_back(w);
                win_col++;
                if (win_col >= ow)
                begin
                    win_col = 0;
                    win_row++;
                end
            end
        end
        if (c + 1 >= iw)
        begin
            cur_col = 0;
            cur_row = (r + 1 >= ih) ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(logic [15:0] px, logic [15:0] sw, logic [15:0] sh);
        int gap;
        bit took;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel    <= px;
        pix_ch.sample_w <= sw;
        pix_ch.sample_h <= sh;
        do
        begin
            @(negedge clk);
            took = pix_ch.ready;
            @(posedge clk);
        end
        while (!took);
        pool_pixel(px, sw, sh);
        pixels_sent++;
    endtask

    // valid stays up for the next write; the caller drops it after the batch
    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        bit took;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
        store_reg(idx, val);
    endtask

    // hold off until the block has drained, then let it settle
    task automatic drain_block();
        pix_ch.valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        if (res_stall != 0)
        begin
            res_stall    <= res_stall - 1;
            res_ch.ready <= (res_stall == 1);
        end
        else
        begin
            res_gap = pick_gap();
            res_stall    <= res_gap;
            res_ch.ready <= (res_gap == 0);
        end
    end

    // result checking: beat is taken at the next rising edge
    always @(negedge clk)
    begin
        window_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_windows.size() == 0)
            begin
                $display("%0t: unexpected window beat row %0d col %0d", $time,
                         res_ch.out_row, res_ch.out_col);
                error_count++;
            end
            else
            begin
                want = pending_windows.pop_front();
                if (res_ch.max_value !== want.max_value)
                begin
                    $display("%0t: max_value exp %0d got %0d", $time,
                             $signed(want.max_value), res_ch.max_value);
                    error_count++;
                end
                if (res_ch.max_index !== want.max_index)
                begin
                    $display("%0t: max_index exp %0d got %0d", $time,
                             want.max_index, res_ch.max_index);
                    error_count++;
                end
                if (res_ch.out_row !== want.out_row)
                begin
                    $display("%0t: out_row exp %0d got %0d", $time,
                             want.out_row, res_ch.out_row);
                    error_count++;
                end
                if (res_ch.out_col !== want.out_col)
                begin
                    $display("%0t: out_col exp %0d got %0d", $time,
                             want.out_col, res_ch.out_col);
                    error_count++;
                end
                if (res_ch.last_of_plane !== want.last_of_plane)
                begin
                    $display("%0t: last_of_plane exp %0b got %0b", $time,
                             want.last_of_plane, res_ch.last_of_plane);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    typedef struct {
        fmp_pkg::cfg_reg_t idx;
        logic [8:0]        val;
    } reg_row_t;

    // directed plane: 4x4 input, one 3x3 window at the bottom right,
    // one-based index, ties and a maximum outside the window
    reg_row_t    dir_regs [7] = '{
        '{fmp_pkg::CFG_IN_WIDTH, 9'd4}, '{fmp_pkg::CFG_IN_HEIGHT, 9'd4},
        '{fmp_pkg::CFG_OUT_WIDTH, 9'd1}, '{fmp_pkg::CFG_OUT_HEIGHT, 9'd1},
        '{fmp_pkg::CFG_POOL_WIDTH, 9'd3}, '{fmp_pkg::CFG_POOL_HEIGHT, 9'd3},
        '{fmp_pkg::CFG_INDEX_BASE, 9'd1}
    };
    logic [15:0] dir_pix [16] = '{
        16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
        16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h8000, 16'h7FFF
    };
    // first maximum inside the window is at row 1, col 2
    window_t     dir_window = '{16'h7FFF, 17'd7, 8'd0, 8'd0, 1'b1};

    initial
    begin
        int unsigned iw, ih, pw, ph, ow, oh, r, c, plane_no;
        logic [8:0]  raw;
        bit          tie_mode;
        window_t     got;

        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        pix_ch.sample_w = '0;
        pix_ch.sample_h = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        error_count = 0;
        cycle_count = 0;
        pixels_sent = 0;
        quiet = 0;
        res_stall = 0;
        reg_val = '{32, 32, 16, 16, 2, 2, 0};
        cur_col = 0;
        cur_row = 0;
        {step_w, step_h, offs_w, offs_h} = '0;
        {smp_w, smp_h, win_col, win_row} = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_regs[i]) write_reg(dir_regs[i].idx, dir_regs[i].val);
        cfg_ch.valid <= 1'b0;
        foreach (dir_pix[i])
        begin
            send_pixel(dir_pix[i], 16'hFFFF, 16'hFFFF);
            if (i == 15)
            begin
                got = pending_windows[$];
                if (got !== dir_window)
                begin
                    $display("%0t: directed window exp %h got %h", $time, dir_window, got);
                    error_count++;
                end
            end
        end
        drain_block();

        // random planes; the first ones hit the size extremes
        plane_no = 0;
        while (pixels_sent < PIX_TARGET)
        begin
            case (plane_no)
                0: begin iw = 256; ih = 2; pw = 1; ph = 1; ow = 255; oh = 1; end
                1: begin iw = 2; ih = 256; pw = 1; ph = 8; ow = 1; oh = 249; end
                2: begin iw = 2; ih = 2; pw = 1; ph = 1; ow = 1; oh = 1; end
                3: begin iw = 12; ih = 12; pw = 8; ph = 8; ow = 4; oh = 4; end
                default:
                begin
                    iw = $urandom_range(2, 16);
                    ih = $urandom_range(2, 16);
                    pw = $urandom_range(1, (iw - 1 < 8) ? iw - 1 : 8);
                    ph = $urandom_range(1, (ih - 1 < 8) ? ih - 1 : 8);
                    ow = $urandom_range(1, iw - pw);
                    oh = $urandom_range(1, ih - ph);
                end
            endcase
            quiet = ($urandom_range(0, 5) == 0);
            tie_mode = ($urandom_range(0, 3) == 0);

            write_reg(fmp_pkg::CFG_IN_WIDTH, 9'(iw));
            write_reg(fmp_pkg::CFG_IN_HEIGHT, 9'(ih));
            // size codes that clamp to the same value
            raw = (ow == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(ow);
            write_reg(fmp_pkg::CFG_OUT_WIDTH, raw);
            raw = (oh == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(oh);
            write_reg(fmp_pkg::CFG_OUT_HEIGHT, raw);
            raw = (pw == 1 && $urandom_range(0, 1)) ? 9'd0 :
                  (pw == 8 && $urandom_range(0, 1)) ? 9'($urandom_range(8, 15)) : 9'(pw);
            write_reg(fmp_pkg::CFG_POOL_WIDTH, raw);
            raw = (ph == 1 && $urandom_range(0, 1)) ? 9'd0 :
                  (ph == 8 && $urandom_range(0, 1)) ? 9'($urandom_range(8, 15)) : 9'(ph);
            write_reg(fmp_pkg::CFG_POOL_HEIGHT, raw);
            write_reg(fmp_pkg::CFG_INDEX_BASE, 9'($urandom_range(0, 1)));
            // unused register index is ignored
            if ($urandom_range(0, 7) == 0) write_reg(3'd7, 9'($urandom));
            cfg_ch.valid <= 1'b0;

            for (r = 0; r < ih; r++)
                for (c = 0; c < iw; c++)
                    send_pixel(tie_mode ? 16'($urandom_range(0, 2) - 1) : 16'($urandom),
                               16'($urandom), 16'($urandom));
            drain_block();
            plane_no++;
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
